[hw/rtl/fpbr_pkg.sv]
// fpbr_pkg: shared types, widths and helpers for the fictitious play best-response block
// used by fpbr_mac and fictitious_play_best_response_top; depends on nothing
`timescale 1ns / 1ps

package fpbr_pkg;

    localparam int MAX_STRATEGIES = 16;
    localparam int IDX_BITS       = $clog2(MAX_STRATEGIES);
    localparam int SIZE_BITS      = IDX_BITS + 1;
    localparam int ADDR_BITS      = 2 * IDX_BITS;
    localparam int PAYOFF_BITS    = 16;
    localparam int COUNT_BITS     = 16;
    localparam int PROD_BITS      = PAYOFF_BITS + COUNT_BITS + 1;
    localparam int SCORE_BITS     = 36;
    localparam int RUN_BITS       = 48;
    localparam int OPERAND_BITS   = 16;
    localparam int FIELD_IDX_BITS = 4;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_PLAYER  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLS_IN_USE = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE_PAYOFF,
        OP_RECORD_MOVE,
        OP_ADD_PAYOFF,
        OP_DECIDE
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic                fin;
        logic [IDX_BITS-1:0] strat;
    } tag_t;

    function automatic logic [SIZE_BITS-1:0] used_size(input logic [CFG_DATA_BITS-1:0] r);
        logic [SIZE_BITS-1:0] n;
        if (r == '0)
        begin
            n = SIZE_BITS'(1);
        end
        else if (32'(r) > MAX_STRATEGIES)
        begin
            n = SIZE_BITS'(MAX_STRATEGIES);
        end
        else
        begin
            n = SIZE_BITS'(r);
        end
        return n;
    endfunction

endpackage

[hw/rtl/fpbr_mac.sv]
// fpbr_mac: shared multiply and saturating accumulate unit, two register stages
// depends on fpbr_pkg
`timescale 1ns / 1ps

module fpbr_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  fpbr_pkg::tag_t                        tag_in,
    input  logic signed [fpbr_pkg::PAYOFF_BITS-1:0] payoff,
    input  logic [fpbr_pkg::COUNT_BITS-1:0]       count,
    output fpbr_pkg::tag_t                        tag_out,
    output logic signed [fpbr_pkg::SCORE_BITS-1:0] acc
);

    localparam int SB = fpbr_pkg::SCORE_BITS;

    fpbr_pkg::tag_t                            tag_a_reg;
    fpbr_pkg::tag_t                            tag_b_reg;
    logic signed [fpbr_pkg::PROD_BITS-1:0]     prod_reg;
    logic signed [fpbr_pkg::PROD_BITS-1:0]     prod_next;
    logic signed [SB-1:0]                      acc_reg;
    logic signed [SB-1:0]                      acc_next;
    logic signed [SB-1:0]                      prod_ext;
    logic signed [SB:0]                        sum_wide;

    always_comb
    begin
        prod_next = $signed(payoff) * $signed({1'b0, count});
        prod_ext  = SB'(prod_reg);
        sum_wide  = {acc_reg[SB-1], acc_reg} + {prod_ext[SB-1], prod_ext};
        if (tag_a_reg.first)
        begin
            acc_next = prod_ext;
        end
        else if (sum_wide[SB] != sum_wide[SB-1])
        begin
            // saturate towards the sign of the true sum
            acc_next = sum_wide[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
        else
        begin
            acc_next = sum_wide[SB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
        end
        else
        begin
            tag_a_reg <= tag_in;
            tag_b_reg <= tag_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (tag_a_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign tag_out = tag_b_reg;
    assign acc     = acc_reg;

endmodule

[hw/rtl/fictitious_play_best_response_top.sv]
// fictitious_play_best_response_top: request handling, payoff memory, counts and decide sequencer
// depends on fpbr_pkg and fpbr_mac
`timescale 1ns / 1ps

// Fictitious play best-response engine. Write, record-move and add-payoff requests, and a
// decide request before any move has been recorded, load their result into the output register
// when taken. A decide with history walks the payoff memory one entry per cycle through its
// single read port and the shared multiply-accumulate unit, over outer * inner entries, where
// outer is the player's own strategy count and inner the opponent's. The input is not ready
// during a decide. A finished result waits in an output register; a new request is taken once
// that register is empty or being emptied. Configuration writes are accepted in every cycle
// and are to be issued only while the block is idle.
module fictitious_play_best_response_top (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_valid,
    output logic                                        cfg_ready,
    input  logic [fpbr_pkg::CFG_IDX_BITS-1:0]           cfg_index,
    input  logic [fpbr_pkg::CFG_DATA_BITS-1:0]          cfg_data,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [1:0]                                  operation,
    input  logic [fpbr_pkg::FIELD_IDX_BITS-1:0]         row_index,
    input  logic [fpbr_pkg::FIELD_IDX_BITS-1:0]         col_index,
    input  logic signed [fpbr_pkg::OPERAND_BITS-1:0]    operand_value,
    input  logic [fpbr_pkg::FIELD_IDX_BITS-1:0]         fallback_choice,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [fpbr_pkg::FIELD_IDX_BITS-1:0]         chosen_strategy,
    output logic signed [fpbr_pkg::SCORE_BITS-1:0]      best_score,
    output logic signed [fpbr_pkg::RUN_BITS-1:0]        running_payoff,
    output logic                                        used_fallback
);

    localparam int IB = fpbr_pkg::IDX_BITS;
    localparam int NB = fpbr_pkg::SIZE_BITS;
    localparam int RB = fpbr_pkg::RUN_BITS;
    localparam int SB = fpbr_pkg::SCORE_BITS;
    localparam int CB = fpbr_pkg::COUNT_BITS;
    localparam int PB = fpbr_pkg::PAYOFF_BITS;

    fpbr_pkg::state_t state_reg;
    fpbr_pkg::state_t state_next;
    fpbr_pkg::op_t    op;

    logic                              row_player_reg;
    logic [fpbr_pkg::CFG_DATA_BITS-1:0] rows_reg;
    logic [fpbr_pkg::CFG_DATA_BITS-1:0] cols_reg;

    logic [CB-1:0]          counts_reg [fpbr_pkg::MAX_STRATEGIES];
    logic signed [RB-1:0]   cum_reg;
    logic signed [RB-1:0]   cum_next;
    logic signed [RB:0]     cum_wide;
    logic                   seen_reg;

    logic signed [PB-1:0]   payoff_mem [fpbr_pkg::MAX_STRATEGIES * fpbr_pkg::MAX_STRATEGIES];
    logic signed [PB-1:0]   rd_reg;
    logic [CB-1:0]          cnt1_reg;
    fpbr_pkg::tag_t         tag1_reg;
    fpbr_pkg::tag_t         issue_tag;
    fpbr_pkg::tag_t         mac_tag;
    logic signed [SB-1:0]   mac_acc;

    logic [IB-1:0]          s_reg;
    logic [IB-1:0]          s_next;
    logic [IB-1:0]          k_reg;
    logic [IB-1:0]          k_next;
    logic [fpbr_pkg::ADDR_BITS-1:0] rd_addr;
    logic [fpbr_pkg::ADDR_BITS-1:0] wr_addr;

    logic signed [SB-1:0]   best_reg;
    logic [IB-1:0]          best_idx_reg;
    logic                   take;

    logic                   out_valid_reg;
    logic [IB-1:0]          chosen_reg;
    logic signed [SB-1:0]   score_reg;
    logic signed [RB-1:0]   run_out_reg;
    logic                   used_fb_reg;

    logic [NB-1:0]          nr;
    logic [NB-1:0]          nc;
    logic [NB-1:0]          outer_n;
    logic [NB-1:0]          inner_n;
    logic                   accept;
    logic                   out_free;
    logic                   mem_we;
    logic                   move_ok;
    logic [IB-1:0]          move_idx;
    logic [IB-1:0]          fb_clamped;
    logic                   quick_load;
    logic                   done_load;

    assign op       = fpbr_pkg::op_t'(operation);
    assign nr       = fpbr_pkg::used_size(rows_reg);
    assign nc       = fpbr_pkg::used_size(cols_reg);
    assign outer_n  = row_player_reg ? nr : nc;
    assign inner_n  = row_player_reg ? nc : nr;
    assign out_free = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign mem_we   = accept && (op == fpbr_pkg::OP_WRITE_PAYOFF);
    assign wr_addr  = {row_index[IB-1:0], col_index[IB-1:0]};
    assign rd_addr  = row_player_reg ? {s_reg, k_reg} : {k_reg, s_reg};
    assign move_ok  = (operand_value[fpbr_pkg::OPERAND_BITS-1:IB] == '0);
    assign move_idx = operand_value[IB-1:0];
    assign fb_clamped = ({1'b0, fallback_choice[IB-1:0]} < outer_n) ? fallback_choice[IB-1:0]
                                                                    : IB'(outer_n - NB'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fpbr_pkg::ST_IDLE:
            begin
                if (accept && (op == fpbr_pkg::OP_DECIDE) && seen_reg)
                begin
                    state_next = fpbr_pkg::ST_ISSUE;
                end
            end
            fpbr_pkg::ST_ISSUE:
            begin
                if (issue_tag.fin)
                begin
                    state_next = fpbr_pkg::ST_DRAIN;
                end
            end
            fpbr_pkg::ST_DRAIN:
            begin
                if (mac_tag.valid && mac_tag.last && mac_tag.fin)
                begin
                    state_next = fpbr_pkg::ST_DONE;
                end
            end
            fpbr_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fpbr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fpbr_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and sequencer controls
    always_comb
    begin
        in_ready        = (state_reg == fpbr_pkg::ST_IDLE) && out_free;
        issue_tag       = '0;
        issue_tag.valid = (state_reg == fpbr_pkg::ST_ISSUE);
        issue_tag.first = (k_reg == '0);
        issue_tag.last  = ({1'b0, k_reg} == inner_n - NB'(1));
        issue_tag.fin   = issue_tag.valid && issue_tag.last
                          && ({1'b0, s_reg} == outer_n - NB'(1));
        issue_tag.strat = s_reg;
        quick_load      = accept && !((op == fpbr_pkg::OP_DECIDE) && seen_reg);
        done_load       = (state_reg == fpbr_pkg::ST_DONE) && out_free;
    end

    always_comb
    begin
        s_next = s_reg;
        k_next = k_reg;
        if (state_reg == fpbr_pkg::ST_IDLE)
        begin
            s_next = '0;
            k_next = '0;
        end
        else if (state_reg == fpbr_pkg::ST_ISSUE)
        begin
            if (issue_tag.last)
            begin
                k_next = '0;
                s_next = s_reg + IB'(1);
            end
            else
            begin
                k_next = k_reg + IB'(1);
            end
        end
    end

    always_comb
    begin
        cum_wide = row_player_reg ? ({cum_reg[RB-1], cum_reg} + (RB + 1)'(operand_value))
                                  : ({cum_reg[RB-1], cum_reg} - (RB + 1)'(operand_value));
        cum_next = cum_reg;
        if (accept && (op == fpbr_pkg::OP_ADD_PAYOFF))
        begin
            if (cum_wide[RB] != cum_wide[RB-1])
            begin
                cum_next = cum_wide[RB] ? {1'b1, {(RB-1){1'b0}}} : {1'b0, {(RB-1){1'b1}}};
            end
            else
            begin
                cum_next = cum_wide[RB-1:0];
            end
        end
    end

    assign take = (mac_tag.strat == '0)
                  || (row_player_reg ? (mac_acc > best_reg) : (mac_acc < best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fpbr_pkg::ST_IDLE;
            row_player_reg <= 1'b1;
            rows_reg       <= fpbr_pkg::CFG_DATA_BITS'(fpbr_pkg::MAX_STRATEGIES);
            cols_reg       <= fpbr_pkg::CFG_DATA_BITS'(fpbr_pkg::MAX_STRATEGIES);
            cum_reg        <= '0;
            seen_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            tag1_reg       <= '0;
            s_reg          <= '0;
            k_reg          <= '0;
            for (int i = 0; i < fpbr_pkg::MAX_STRATEGIES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            s_reg     <= s_next;
            k_reg     <= k_next;
            tag1_reg  <= issue_tag;
            cum_reg   <= cum_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fpbr_pkg::CFG_ROW_PLAYER)
                begin
                    row_player_reg <= cfg_data[0];
                end
                else if (cfg_index == fpbr_pkg::CFG_ROWS_IN_USE)
                begin
                    rows_reg <= cfg_data;
                end
                else if (cfg_index == fpbr_pkg::CFG_COLS_IN_USE)
                begin
                    cols_reg <= cfg_data;
                end
            end
            if (accept && (op == fpbr_pkg::OP_RECORD_MOVE) && move_ok)
            begin
                seen_reg <= 1'b1;
                if (counts_reg[move_idx] != {CB{1'b1}})
                begin
                    counts_reg[move_idx] <= counts_reg[move_idx] + CB'(1);
                end
            end
            if (quick_load || done_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            payoff_mem[wr_addr] <= PB'(operand_value);
        end
        rd_reg <= payoff_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        cnt1_reg <= counts_reg[k_reg];
        if (mac_tag.valid && mac_tag.last && take)
        begin
            best_reg     <= mac_acc;
            best_idx_reg <= mac_tag.strat;
        end
        if (quick_load)
        begin
            chosen_reg  <= (op == fpbr_pkg::OP_DECIDE) ? fb_clamped : '0;
            score_reg   <= '0;
            run_out_reg <= cum_next;
            used_fb_reg <= (op == fpbr_pkg::OP_DECIDE);
        end
        else if (done_load)
        begin
            chosen_reg  <= best_idx_reg;
            score_reg   <= best_reg;
            run_out_reg <= cum_reg;
            used_fb_reg <= 1'b0;
        end
    end

    fpbr_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag1_reg),
        .payoff  (rd_reg),
        .count   (cnt1_reg),
        .tag_out (mac_tag),
        .acc     (mac_acc)
    );

    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign chosen_strategy = fpbr_pkg::FIELD_IDX_BITS'(chosen_reg);
    assign best_score      = score_reg;
    assign running_payoff  = run_out_reg;
    assign used_fallback   = used_fb_reg;

`ifndef SYNTHESIS
    a_mac_only_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
        mac_tag.valid |-> (state_reg == fpbr_pkg::ST_ISSUE || state_reg == fpbr_pkg::ST_DRAIN))
        else $error("mac result outside a decide");

    a_fallback_zero_score: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && used_fallback) |-> (best_score == '0))
        else $error("fallback result with non-zero score");

    a_done_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpbr_pkg::ST_DRAIN && state_next == fpbr_pkg::ST_DONE)
        |=> (best_idx_reg < IB'(outer_n) || outer_n == NB'(fpbr_pkg::MAX_STRATEGIES)))
        else $error("decide finished with strategy out of range");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fpbr_pkg::ST_ISSUE) |=> !$past(accept))
        else $error("request accepted during a decide");
`endif

endmodule

[bench/fictitious_play_best_response_top_test.sv]
`timescale 1ns / 1ps
// fictitious_play_best_response_top_test: self-checking bench for the fictitious play block,
// checking every result of random payoff, move, round and decide requests against its own
// model of the game state; depends on fpbr_pkg and fictitious_play_best_response_top

module fictitious_play_best_response_top_test;

    localparam int     CYCLE_LIMIT = 4_000_000;
    localparam longint SCORE_TOP   = (longint'(1) <<< (fpbr_pkg::SCORE_BITS - 1)) - 1;
    localparam longint RUN_TOP     = (longint'(1) <<< (fpbr_pkg::RUN_BITS - 1)) - 1;

    typedef struct packed {
        fpbr_pkg::op_t                             op;
        logic [fpbr_pkg::FIELD_IDX_BITS-1:0]       row;
        logic [fpbr_pkg::FIELD_IDX_BITS-1:0]       col;
        logic signed [fpbr_pkg::OPERAND_BITS-1:0]  value;
        logic [fpbr_pkg::FIELD_IDX_BITS-1:0]       fb;
    } request_t;

    typedef struct packed {
        logic [fpbr_pkg::FIELD_IDX_BITS-1:0]       strat;
        logic signed [fpbr_pkg::SCORE_BITS-1:0]    score;
        logic signed [fpbr_pkg::RUN_BITS-1:0]      run;
        logic                                      fell;
    } answer_t;

    logic                                          clk = 1'b0;
    logic                                          rst_n = 1'b0;
    logic                                          cfg_valid = 1'b0;
    logic                                          cfg_ready;
    logic [fpbr_pkg::CFG_IDX_BITS-1:0]             cfg_index = '0;
    logic [fpbr_pkg::CFG_DATA_BITS-1:0]            cfg_data = '0;
    logic                                          in_valid = 1'b0;
    logic                                          in_ready;
    logic [1:0]                                    operation = '0;
    logic [fpbr_pkg::FIELD_IDX_BITS-1:0]           row_index = '0;
    logic [fpbr_pkg::FIELD_IDX_BITS-1:0]           col_index = '0;
    logic signed [fpbr_pkg::OPERAND_BITS-1:0]      operand_value = '0;
    logic [fpbr_pkg::FIELD_IDX_BITS-1:0]           fallback_choice = '0;
    logic                                          out_valid;
    logic                                          out_ready = 1'b0;
    logic [fpbr_pkg::FIELD_IDX_BITS-1:0]           chosen_strategy;
    logic signed [fpbr_pkg::SCORE_BITS-1:0]        best_score;
    logic signed [fpbr_pkg::RUN_BITS-1:0]          running_payoff;
    logic                                          used_fallback;

    // model of the game state
    logic signed [fpbr_pkg::PAYOFF_BITS-1:0]
        payoff_grid [fpbr_pkg::MAX_STRATEGIES][fpbr_pkg::MAX_STRATEGIES];
    logic [fpbr_pkg::COUNT_BITS-1:0]
        move_tally [fpbr_pkg::MAX_STRATEGIES] = '{default: '0};
    longint                                        run_total = 0;
    bit                                            history_seen = 1'b0;
    logic                                          game_row = 1'b1;
    logic [fpbr_pkg::CFG_DATA_BITS-1:0]            game_rows = 5'd16;
    logic [fpbr_pkg::CFG_DATA_BITS-1:0]            game_cols = 5'd16;

    // what the request generator knows of the game
    bit           gen_written [fpbr_pkg::MAX_STRATEGIES][fpbr_pkg::MAX_STRATEGIES];
    bit           gen_seen = 1'b0;
    logic         gen_row = 1'b1;
    int           gen_nr = 16;
    int           gen_nc = 16;

    request_t                            request_queue [$];
    answer_t                             awaited_answers [$];
    int                                  failures = 0;
    int                                  cycle_count = 0;
    int                                  gap_left = 0;
    int                                  stall_left = 0;
    bit                                  quiet = 1'b0;

    fictitious_play_best_response_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .row_index       (row_index),
        .col_index       (col_index),
        .operand_value   (operand_value),
        .fallback_choice (fallback_choice),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .chosen_strategy (chosen_strategy),
        .best_score      (best_score),
        .running_payoff  (running_payoff),
        .used_fallback   (used_fallback)
    );

    always #5 clk = ~clk;

    function automatic longint clip(input longint x, input longint top);
        return x > top ? top : (x < -top - 1 ? -top - 1 : x);
    endfunction

    function automatic int in_use(input logic [fpbr_pkg::CFG_DATA_BITS-1:0] r);
        if (r == '0)
        begin
            return 1;
        end
        return int'(r) > fpbr_pkg::MAX_STRATEGIES ? fpbr_pkg::MAX_STRATEGIES : int'(r);
    endfunction

    function automatic longint strategy_score(input int s, input int inner);
        longint sum;
        longint p;
        sum = 0;
        for (int k = 0; k < inner; k++)
        begin
            p = game_row ? longint'(payoff_grid[s][k]) : longint'(payoff_grid[k][s]);
            sum = clip(sum + clip(p * longint'(move_tally[k]), SCORE_TOP), SCORE_TOP);
        end
        return sum;
    endfunction

    function automatic answer_t advance_game(input request_t q);
        answer_t a;
        int      v;
        int      n;
        int      inner;
        longint  best;
        longint  t;
        a = '0;
        v = q.value;
        case (q.op)
            fpbr_pkg::OP_WRITE_PAYOFF:
            begin
                payoff_grid[q.row][q.col] = q.value;
            end
            fpbr_pkg::OP_RECORD_MOVE:
            begin
                if (v >= 0 && v < fpbr_pkg::MAX_STRATEGIES)
                begin
                    if (move_tally[v] != '1)
                    begin
                        move_tally[v] = move_tally[v] + 1'b1;
                    end
                    history_seen = 1'b1;
                end
            end
            fpbr_pkg::OP_ADD_PAYOFF:
            begin
                run_total = clip(game_row ? run_total + v : run_total - v, RUN_TOP);
            end
            default:
            begin
                n = game_row ? in_use(game_rows) : in_use(game_cols);
                if (!history_seen)
                begin
                    a.strat = int'(q.fb) < n ? q.fb : fpbr_pkg::FIELD_IDX_BITS'(n - 1);
                    a.fell  = 1'b1;
                end
                else
                begin
                    inner = game_row ? in_use(game_cols) : in_use(game_rows);
                    best  = strategy_score(0, inner);
                    for (int s = 1; s < n; s++)
                    begin
                        t = strategy_score(s, inner);
                        if (game_row ? (t > best) : (t < best))
                        begin
                            best    = t;
                            a.strat = fpbr_pkg::FIELD_IDX_BITS'(s);
                        end
                    end
                    a.score = best[fpbr_pkg::SCORE_BITS-1:0];
                end
            end
        endcase
        a.run = run_total[fpbr_pkg::RUN_BITS-1:0];
        return a;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        return r < 90 ? $urandom_range(1, 3) : $urandom_range(4, 30);
    endfunction

    function automatic logic signed [fpbr_pkg::OPERAND_BITS-1:0] any_payoff();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return 16'sh7fff;
        end
        if (pick == 1)
        begin
            return 16'sh8000;
        end
        if (pick < 4)
        begin
            // small values make ties likely
            return fpbr_pkg::OPERAND_BITS'(int'($urandom_range(0, 6)) - 3);
        end
        return fpbr_pkg::OPERAND_BITS'($urandom);
    endfunction

    function automatic void queue_request(input fpbr_pkg::op_t op, input logic [3:0] r,
                                          input logic [3:0] c,
                                          input logic signed [fpbr_pkg::OPERAND_BITS-1:0] v,
                                          input logic [3:0] fb);
        request_t q;
        q = '{op: op, row: r, col: c, value: v, fb: fb};
        request_queue.push_back(q);
        if (op == fpbr_pkg::OP_WRITE_PAYOFF)
        begin
            gen_written[r][c] = 1'b1;
        end
        else if (op == fpbr_pkg::OP_RECORD_MOVE && v >= 0 && v < fpbr_pkg::MAX_STRATEGIES)
        begin
            gen_seen = 1'b1;
        end
    endfunction

    // a decide with history reads the whole area in use, so fill any holes first
    function automatic void queue_decide(input logic [3:0] fb);
        if (gen_seen)
        begin
            for (int r = 0; r < gen_nr; r++)
            begin
                for (int c = 0; c < gen_nc; c++)
                begin
                    if (!gen_written[r][c])
                    begin
                        queue_request(fpbr_pkg::OP_WRITE_PAYOFF, 4'(r), 4'(c), any_payoff(),
                                      4'($urandom));
                    end
                end
            end
        end
        queue_request(fpbr_pkg::OP_DECIDE, 4'($urandom), 4'($urandom),
                      fpbr_pkg::OPERAND_BITS'($urandom), fb);
    endfunction

    task automatic settle(input int cycles);
        while (request_queue.size() != 0 || in_valid || awaited_answers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fpbr_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [fpbr_pkg::CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        case (idx)
            fpbr_pkg::CFG_ROW_PLAYER:  game_row  = val[0];
            fpbr_pkg::CFG_ROWS_IN_USE: game_rows = val;
            fpbr_pkg::CFG_COLS_IN_USE: game_cols = val;
            default: ;
        endcase
    endtask

    task automatic set_game(input logic rp, input logic [fpbr_pkg::CFG_DATA_BITS-1:0] rows,
                            input logic [fpbr_pkg::CFG_DATA_BITS-1:0] cols);
        settle(10);
        write_reg(fpbr_pkg::CFG_ROW_PLAYER, fpbr_pkg::CFG_DATA_BITS'(rp));
        write_reg(fpbr_pkg::CFG_ROWS_IN_USE, rows);
        write_reg(fpbr_pkg::CFG_COLS_IN_USE, cols);
        gen_row = rp;
        gen_nr  = in_use(rows);
        gen_nc  = in_use(cols);
        @(negedge clk);
    endtask

    task automatic run_phase(input logic rp, input logic [fpbr_pkg::CFG_DATA_BITS-1:0] rows,
                             input logic [fpbr_pkg::CFG_DATA_BITS-1:0] cols, input int count,
                             input bit calm);
        int                                       pick;
        int                                       opp;
        logic signed [fpbr_pkg::OPERAND_BITS-1:0] v;
        set_game(rp, rows, cols);
        quiet = calm;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            opp  = gen_row ? gen_nc : gen_nr;
            if (pick < 30)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    queue_request(fpbr_pkg::OP_WRITE_PAYOFF, 4'($urandom_range(0, gen_nr - 1)),
                                  4'($urandom_range(0, gen_nc - 1)), any_payoff(),
                                  4'($urandom));
                end
                else
                begin
                    queue_request(fpbr_pkg::OP_WRITE_PAYOFF, 4'($urandom), 4'($urandom),
                                  any_payoff(), 4'($urandom));
                end
            end
            else if (pick < 55)
            begin
                case ($urandom_range(0, 9))
                    0:       v = fpbr_pkg::OPERAND_BITS'($urandom);
                    1:       v = fpbr_pkg::OPERAND_BITS'(-int'($urandom_range(1, 32768)));
                    2:       v = fpbr_pkg::OPERAND_BITS'($urandom_range(16, 32767));
                    3:       v = fpbr_pkg::OPERAND_BITS'($urandom_range(0, 15));
                    default: v = fpbr_pkg::OPERAND_BITS'($urandom_range(0, opp - 1));
                endcase
                queue_request(fpbr_pkg::OP_RECORD_MOVE, 4'($urandom), 4'($urandom), v,
                              4'($urandom));
            end
            else if (pick < 75)
            begin
                queue_request(fpbr_pkg::OP_ADD_PAYOFF, 4'($urandom), 4'($urandom),
                              any_payoff(), 4'($urandom));
            end
            else
            begin
                queue_decide(4'($urandom));
            end
        end
    endtask

    // request driver
    always @(posedge clk)
    begin
        bit       took;
        request_t held;
        request_t offer;
        took = in_valid && in_ready;
        if (took)
        begin
            held.op    = fpbr_pkg::op_t'(operation);
            held.row   = row_index;
            held.col   = col_index;
            held.value = operand_value;
            held.fb    = fallback_choice;
            awaited_answers.push_back(advance_game(held));
        end
        if (!in_valid || took)
        begin
            if (gap_left != 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (rst_n && request_queue.size() != 0)
            begin
                offer = request_queue.pop_front();
                operation       <= offer.op;
                row_index       <= offer.row;
                col_index       <= offer.col;
                operand_value   <= offer.value;
                fallback_choice <= offer.fb;
                in_valid        <= 1'b1;
                gap_left        <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        answer_t want;
        if (out_valid && out_ready)
        begin
            if (awaited_answers.size() == 0)
            begin
                $error("result with no request outstanding");
                failures++;
            end
            else
            begin
                want = awaited_answers.pop_front();
                if (chosen_strategy !== want.strat)
                begin
                    $error("chosen_strategy: expected %0d, got %0d", want.strat,
                           chosen_strategy);
                    failures++;
                end
                if (best_score !== want.score)
                begin
                    $error("best_score: expected %0d, got %0d", want.score, best_score);
                    failures++;
                end
                if (running_payoff !== want.run)
                begin
                    $error("running_payoff: expected %0d, got %0d", want.run,
                           running_payoff);
                    failures++;
                end
                if (used_fallback !== want.fell)
                begin
                    $error("used_fallback: expected %0d, got %0d", want.fell, used_fallback);
                    failures++;
                end
            end
        end
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            stall_left <= pick_gap();
            out_ready  <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // no history yet: fallback clamping, ignored moves, round payoff extremes
        set_game(1'b1, 5'd3, 5'd2);
        queue_request(fpbr_pkg::OP_DECIDE, 4'd0, 4'd0, 16'sd0, 4'd15);
        queue_request(fpbr_pkg::OP_DECIDE, 4'd15, 4'd15, -16'sd1, 4'd0);
        queue_request(fpbr_pkg::OP_ADD_PAYOFF, 4'd0, 4'd0, 16'sh7fff, 4'd5);
        queue_request(fpbr_pkg::OP_ADD_PAYOFF, 4'd0, 4'd0, 16'sh8000, 4'd5);
        queue_request(fpbr_pkg::OP_RECORD_MOVE, 4'd0, 4'd0, -16'sd1, 4'd0);
        queue_request(fpbr_pkg::OP_RECORD_MOVE, 4'd0, 4'd0, 16'sd16, 4'd0);
        queue_request(fpbr_pkg::OP_RECORD_MOVE, 4'd0, 4'd0, 16'sh8000, 4'd0);
        queue_request(fpbr_pkg::OP_DECIDE, 4'd0, 4'd0, 16'sd0, 4'd1);

        // column player: subtraction, first history, ties and a clear minimum
        set_game(1'b0, 5'd2, 5'd2);
        queue_request(fpbr_pkg::OP_DECIDE, 4'd15, 4'd15, 16'sh7fff, 4'd15);
        queue_request(fpbr_pkg::OP_ADD_PAYOFF, 4'd0, 4'd0, 16'sh7fff, 4'd0);
        queue_request(fpbr_pkg::OP_RECORD_MOVE, 4'd0, 4'd0, 16'sh7fff, 4'd0);
        queue_request(fpbr_pkg::OP_RECORD_MOVE, 4'd0, 4'd0, 16'sd0, 4'd0);
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                queue_request(fpbr_pkg::OP_WRITE_PAYOFF, 4'(r), 4'(c), 16'sd7, 4'd0);
            end
        end
        queue_decide(4'd9);
        queue_request(fpbr_pkg::OP_WRITE_PAYOFF, 4'd0, 4'd1, 16'sh8000, 4'd0);
        queue_decide(4'd9);
        queue_request(fpbr_pkg::OP_RECORD_MOVE, 4'd0, 4'd0, 16'sd1, 4'd0);
        queue_request(fpbr_pkg::OP_WRITE_PAYOFF, 4'd1, 4'd0, 16'sh8000, 4'd0);
        queue_decide(4'd9);
        queue_request(fpbr_pkg::OP_WRITE_PAYOFF, 4'd15, 4'd15, 16'sh7fff, 4'd0);

        run_phase(1'b1, 5'd3, 5'd2, 200, 1'b0);
        run_phase(1'b0, 5'd4, 5'd5, 200, 1'b1);
        run_phase(1'b1, 5'd1, 5'd1, 150, 1'b0);
        run_phase(1'b0, 5'd1, 5'd16, 100, 1'b0);
        run_phase(1'b1, 5'd16, 5'd16, 150, 1'b0);
        run_phase(1'b0, 5'd16, 5'd16, 100, 1'b1);
        run_phase(1'b1, 5'd0, 5'd31, 100, 1'b0);
        run_phase(1'b0, 5'd31, 5'd0, 100, 1'b0);
        run_phase(1'b1, 5'd2, 5'd7, 200, 1'b0);
        run_phase(1'b0, 5'd6, 5'd3, 200, 1'b1);

        settle(300);
        if (failures == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[files.f]
hw/rtl/fpbr_pkg.sv
hw/rtl/fpbr_mac.sv
hw/rtl/fictitious_play_best_response_top.sv
bench/fictitious_play_best_response_top_test.sv
